[src/ptss_pkg.sv]
// ----------------------------------------------------------------------------
// ptss_pkg: shared constants for the point-in-triangle same-side unit
// Register map codes and configuration bus sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package ptss_pkg;

   // configuration bus: registers are wider than 32 bits, so 64-bit data
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_ADDR_LSB  = 3;

   typedef enum logic [1:0] {
      REG_ORIGIN = 2'd0,
      REG_EDGE_A = 2'd1,
      REG_EDGE_B = 2'd2
   } csr_reg_type;

endpackage

`default_nettype wire

[src/ptss_if.sv]
// ----------------------------------------------------------------------------
// ptss_if: request and response channels
// Valid/ready channels carrying a query point and the inside flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptss_req_if #(
   parameter int W = 16
);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] query_x;
   logic signed [W-1:0] query_y;
   logic signed [W-1:0] query_z;

   modport source (output valid, output query_x, output query_y, output query_z,
                   input ready);
   modport sink   (input valid, input query_x, input query_y, input query_z,
                   output ready);
endinterface

interface ptss_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, output inside_res, input ready);
   modport sink   (input valid, input inside_res, output ready);
endinterface

`default_nettype wire

[src/point_in_triangle_same_side_unit.sv]
// ----------------------------------------------------------------------------
// point_in_triangle_same_side_unit: 3D point-in-triangle, same-side method
// Holds a triangle as origin plus edges A and B and tests query points against
// every triangle edge with exact integer cross and dot products.
// ----------------------------------------------------------------------------
//   channel   dir   handshake           payload
//   req_if    in    valid/ready         query_x, query_y, query_z
//   rsp_if    out   valid/ready         inside_res
//   csr_*     in    APB write, pready=1 origin_xyz @0x00, edge_a_xyz @0x08,
//                                       edge_b_xyz @0x10
//
// One request per cycle unless stalled. Stages: query offset stage, the
// cross product (multiply, subtract) and the split dot product (multiply,
// combine, sum) stages, then the output register. Each stage holds its own
// valid bit and loads whenever it is empty or the next stage moves, so
// bubbles collapse and a stalled response only blocks requests once the
// pipe is full. Reset clears the valid bits and the triangle registers.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_triangle_same_side_unit
   import ptss_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   ptss_req_if.sink                      req_if,
   ptss_rsp_if.source                    rsp_if,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready
);

   localparam int C    = COORD_BITS;
   localparam int FW   = 3 * C;
   localparam int RW   = (FW > CSR_DATA_BITS) ? CSR_DATA_BITS : FW;
   localparam int AW   = C + 1;
   localparam int BW   = C + 2;
   localparam int CW   = AW + BW + 1;
   localparam int NSTG = 7;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [RW-1:0] origin_ff;
   logic [RW-1:0] edge_a_ff;
   logic [RW-1:0] edge_b_ff;
   logic          csr_wr;
   csr_reg_type   csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_reg_type'(csr_paddr[CSR_ADDR_BITS-1:CSR_ADDR_LSB]);

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
         edge_a_ff <= '0;
         edge_b_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_ORIGIN: origin_ff <= csr_pwdata[RW-1:0];
            REG_EDGE_A: edge_a_ff <= csr_pwdata[RW-1:0];
            REG_EDGE_B: edge_b_ff <= csr_pwdata[RW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_ORIGIN: csr_prdata = CSR_DATA_BITS'(origin_ff);
         REG_EDGE_A: csr_prdata = CSR_DATA_BITS'(edge_a_ff);
         REG_EDGE_B: csr_prdata = CSR_DATA_BITS'(edge_b_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // unpack fields; z bits cut off by the bus width read as zero
   logic [FW-1:0]       origin_full;
   logic [FW-1:0]       edge_a_full;
   logic [FW-1:0]       edge_b_full;
   logic signed [C-1:0] v0   [3];
   logic signed [C-1:0] ea   [3];
   logic signed [C-1:0] eb   [3];

   assign origin_full = FW'(origin_ff);
   assign edge_a_full = FW'(edge_a_ff);
   assign edge_b_full = FW'(edge_b_ff);

   for (genvar i = 0; i < 3; i++) begin : g_unpack
      assign v0[i] = origin_full[i*C +: C];
      assign ea[i] = edge_a_full[i*C +: C];
      assign eb[i] = edge_b_full[i*C +: C];
   end

   // ------------------------------------------------------------------
   // triangle-only terms, refreshed every cycle
   // ------------------------------------------------------------------
   logic signed [AW-1:0] ea_k_in  [3];
   logic signed [AW-1:0] eb_k_in  [3];
   logic signed [AW-1:0] e1_k_in  [3];
   logic signed [AW-1:0] nea_k_in [3];
   logic signed [AW-1:0] ea_k_ff  [3];
   logic signed [AW-1:0] eb_k_ff  [3];
   logic signed [AW-1:0] e1_k_ff  [3];
   logic signed [AW-1:0] nea_k_ff [3];
   logic signed [BW-1:0] nea_k_b  [3];
   logic signed [BW-1:0] ea_k_b   [3];
   logic signed [BW-1:0] eb_k_b   [3];

   for (genvar i = 0; i < 3; i++) begin : g_tri
      always_comb begin
         ea_k_in[i]  = AW'(ea[i]);
         eb_k_in[i]  = AW'(eb[i]);
         e1_k_in[i]  = AW'(eb[i]) - AW'(ea[i]);
         nea_k_in[i] = -AW'(ea[i]);
         nea_k_b[i]  = BW'(nea_k_ff[i]);
         ea_k_b[i]   = BW'(ea_k_ff[i]);
         eb_k_b[i]   = BW'(eb_k_ff[i]);
      end

      always_ff @(posedge clock) begin
         ea_k_ff[i]  <= ea_k_in[i];
         eb_k_ff[i]  <= eb_k_in[i];
         e1_k_ff[i]  <= e1_k_in[i];
         nea_k_ff[i] <= nea_k_in[i];
      end
   end

   // cross products of each edge with the opposite vertex offset
   logic signed [CW-1:0] cq1 [3];
   logic signed [CW-1:0] cq2 [3];
   logic signed [CW-1:0] cq3 [3];

   ptss_cross #(.AW(AW), .BW(BW)) u_cq1 (
      .clock(clock), .en_mul(1'b1), .en_sub(1'b1),
      .a_vec(e1_k_ff), .b_vec(nea_k_b), .c_vec(cq1)
   );
   ptss_cross #(.AW(AW), .BW(BW)) u_cq2 (
      .clock(clock), .en_mul(1'b1), .en_sub(1'b1),
      .a_vec(eb_k_ff), .b_vec(ea_k_b), .c_vec(cq2)
   );
   ptss_cross #(.AW(AW), .BW(BW)) u_cq3 (
      .clock(clock), .en_mul(1'b1), .en_sub(1'b1),
      .a_vec(ea_k_ff), .b_vec(eb_k_b), .c_vec(cq3)
   );

   // ------------------------------------------------------------------
   // pipeline control
   // ------------------------------------------------------------------
   logic [NSTG-1:0] v_in;
   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] en;

   always_comb begin
      en[NSTG-1] = !v_ff[NSTG-1] || rsp_if.ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in = {v_ff[NSTG-2:0], req_if.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   assign req_if.ready = en[0];

   // ------------------------------------------------------------------
   // stage 1: query offsets from the origin and from the first edge end
   // ------------------------------------------------------------------
   logic signed [C-1:0]  q      [3];
   logic signed [AW-1:0] dq0_in [3];
   logic signed [BW-1:0] dq1_in [3];
   logic signed [AW-1:0] dq0_ff [3];
   logic signed [BW-1:0] dq1_ff [3];
   logic signed [BW-1:0] dq0_b  [3];
   logic signed [AW-1:0] one_e1 [3];

   assign q[0] = C'(req_if.query_x);
   assign q[1] = C'(req_if.query_y);
   assign q[2] = C'(req_if.query_z);

   for (genvar i = 0; i < 3; i++) begin : g_off
      always_comb begin
         dq0_in[i] = AW'(q[i]) - AW'(v0[i]);
         dq1_in[i] = BW'(q[i]) - BW'(v0[i]) - BW'(ea[i]);
         dq0_b[i]  = BW'(dq0_ff[i]);
         one_e1[i] = e1_k_ff[i];
      end

      always_ff @(posedge clock) begin
         if (en[0]) begin
            dq0_ff[i] <= dq0_in[i];
            dq1_ff[i] <= dq1_in[i];
         end
      end
   end

   // ------------------------------------------------------------------
   // stages 2-3: edge x query offset
   // ------------------------------------------------------------------
   logic signed [CW-1:0] cp1 [3];
   logic signed [CW-1:0] cp2 [3];
   logic signed [CW-1:0] cp3 [3];

   ptss_cross #(.AW(AW), .BW(BW)) u_cp1 (
      .clock(clock), .en_mul(en[1]), .en_sub(en[2]),
      .a_vec(one_e1), .b_vec(dq1_ff), .c_vec(cp1)
   );
   ptss_cross #(.AW(AW), .BW(BW)) u_cp2 (
      .clock(clock), .en_mul(en[1]), .en_sub(en[2]),
      .a_vec(eb_k_ff), .b_vec(dq0_b), .c_vec(cp2)
   );
   ptss_cross #(.AW(AW), .BW(BW)) u_cp3 (
      .clock(clock), .en_mul(en[1]), .en_sub(en[2]),
      .a_vec(ea_k_ff), .b_vec(dq0_b), .c_vec(cp3)
   );

   // ------------------------------------------------------------------
   // stages 4-6: dot product signs, stage 7: combine
   // ------------------------------------------------------------------
   logic pass1;
   logic pass2;
   logic pass3;
   logic inside_in;
   logic inside_ff;

   ptss_dot #(.CW(CW)) u_dot1 (
      .clock(clock), .en_mul(en[3]), .en_term(en[4]), .en_sum(en[5]),
      .p_vec(cp1), .q_vec(cq1), .pass(pass1)
   );
   ptss_dot #(.CW(CW)) u_dot2 (
      .clock(clock), .en_mul(en[3]), .en_term(en[4]), .en_sum(en[5]),
      .p_vec(cp2), .q_vec(cq2), .pass(pass2)
   );
   ptss_dot #(.CW(CW)) u_dot3 (
      .clock(clock), .en_mul(en[3]), .en_term(en[4]), .en_sum(en[5]),
      .p_vec(cp3), .q_vec(cq3), .pass(pass3)
   );

   assign inside_in = pass1 && pass2 && pass3;

   always_ff @(posedge clock) begin
      if (en[NSTG-1]) begin
         inside_ff <= inside_in;
      end
   end

   assign rsp_if.valid      = v_ff[NSTG-1];
   assign rsp_if.inside_res = inside_ff;

endmodule

`default_nettype wire

[src/ptss_cross.sv]
// ----------------------------------------------------------------------------
// ptss_cross: two-stage signed 3D cross product
// First stage forms the six partial products, second takes the differences.
// ----------------------------------------------------------------------------
`default_nettype none

module ptss_cross #(
   parameter int AW = 17,
   parameter int BW = 18
) (
   input  wire logic                  clock,
   input  wire logic                  en_mul,
   input  wire logic                  en_sub,
   input  wire logic signed [AW-1:0]  a_vec [3],
   input  wire logic signed [BW-1:0]  b_vec [3],
   output logic signed [AW+BW:0]      c_vec [3]
);

   localparam int PW = AW + BW;
   localparam int CW = PW + 1;

   logic signed [PW-1:0] pa_in [3];
   logic signed [PW-1:0] pb_in [3];
   logic signed [PW-1:0] pa_ff [3];
   logic signed [PW-1:0] pb_ff [3];
   logic signed [CW-1:0] c_in  [3];
   logic signed [CW-1:0] c_ff  [3];

   for (genvar i = 0; i < 3; i++) begin : g_comp
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;

      always_comb begin
         pa_in[i] = a_vec[J] * b_vec[K];
         pb_in[i] = a_vec[K] * b_vec[J];
         c_in[i]  = CW'(pa_ff[i]) - CW'(pb_ff[i]);
      end

      always_ff @(posedge clock) begin
         if (en_mul) begin
            pa_ff[i] <= pa_in[i];
            pb_ff[i] <= pb_in[i];
         end
         if (en_sub) begin
            c_ff[i] <= c_in[i];
         end
      end

      assign c_vec[i] = c_ff[i];
   end

endmodule

`default_nettype wire

[src/ptss_dot.sv]
// ----------------------------------------------------------------------------
// ptss_dot: three-stage dot product sign test
// Splits one operand into halves so each multiplier stays narrow, then sums
// per component and across components; flags a result that is not negative.
// ----------------------------------------------------------------------------
`default_nettype none

module ptss_dot #(
   parameter int CW = 36
) (
   input  wire logic                 clock,
   input  wire logic                 en_mul,
   input  wire logic                 en_term,
   input  wire logic                 en_sum,
   input  wire logic signed [CW-1:0] p_vec [3],
   input  wire logic signed [CW-1:0] q_vec [3],
   output logic                      pass
);

   localparam int K   = CW / 2;
   localparam int PLW = CW + K + 1;
   localparam int PHW = CW + (CW - K);
   localparam int TW  = 2 * CW + 2;

   logic signed [PLW-1:0] pl_in   [3];
   logic signed [PLW-1:0] pl_ff   [3];
   logic signed [PHW-1:0] ph_in   [3];
   logic signed [PHW-1:0] ph_ff   [3];
   logic signed [TW-1:0]  term_in [3];
   logic signed [TW-1:0]  term_ff [3];
   logic signed [TW-1:0]  total;
   logic                  pass_in;
   logic                  pass_ff;

   for (genvar i = 0; i < 3; i++) begin : g_comp
      logic signed [CW-K-1:0] q_hi;
      logic signed [K:0]      q_lo;

      always_comb begin
         q_hi       = q_vec[i][CW-1:K];
         q_lo       = signed'({1'b0, q_vec[i][K-1:0]});
         pl_in[i]   = p_vec[i] * q_lo;
         ph_in[i]   = p_vec[i] * q_hi;
         term_in[i] = (TW'(ph_ff[i]) <<< K) + TW'(pl_ff[i]);
      end

      always_ff @(posedge clock) begin
         if (en_mul) begin
            pl_ff[i] <= pl_in[i];
            ph_ff[i] <= ph_in[i];
         end
         if (en_term) begin
            term_ff[i] <= term_in[i];
         end
      end
   end

   always_comb begin
      total   = term_ff[0] + term_ff[1] + term_ff[2];
      pass_in = ~total[TW-1];
   end

   always_ff @(posedge clock) begin
      if (en_sum) begin
         pass_ff <= pass_in;
      end
   end

   assign pass = pass_ff;

endmodule

`default_nettype wire
